FILE: hdl/plr_pkg.sv
// Shared types and constants of the polyphase line resampler.
package plr_pkg;

  localparam int unsigned TAPS           = 6;
  localparam int unsigned CH             = 4;
  localparam int unsigned MAX_PHASES_DEF = 32;
  localparam int unsigned MAX_RESULTS    = 64;

  localparam logic signed [27:0] SUM_MAX       = 28'sh03F_FFFF;
  localparam logic [9:0]         OCOUNT_RESET  = 10'd2;
  localparam logic [5:0]         PCOUNT_RESET  = 6'd1;
  localparam logic [31:0]        PATTERN_RESET = 32'h0000_0001;
  localparam logic [8:0]         LIMIT_RESET   = 9'd511;

  typedef enum logic [1:0] {
    KIND_PIXEL = 2'd0,
    KIND_FLUSH = 2'd1,
    KIND_COEF  = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    CFG_PHASE_COUNT = 2'd0,
    CFG_ADVANCE     = 2'd1,
    CFG_LINE_LIMIT  = 2'd2
  } cfg_e;

  typedef enum logic [1:0] {
    PRE_FIRST  = 2'd0,
    PRE_SECOND = 2'd1,
    PRE_RUN    = 2'd2,
    PRE_OWED   = 2'd3
  } preload_e;

  typedef logic [31:0]         pix_t;
  typedef pix_t [TAPS-1:0]     win_t;

  typedef struct packed {
    logic last;
    logic done;
  } tag_t;

endpackage

FILE: hdl/polyphase_line_resampler_core.sv
// Top level of the horizontal polyphase line resampler (six taps, four byte channels).
//
// The block takes one input word per cycle into an input register while in_stall_o is low and
// hands it to an output sequencer. A coefficient write, a preload pixel, an ignored word or a
// flush before any pixel passes the sequencer and gives no result. A pixel or a flush that
// produces k results issues one result word per cycle while the output does not stall, so the
// sustained rate is set by the number of output phases per input pixel. Each result then passes
// the coefficient memory read, the register of the 24 byte-by-coefficient products and the
// output register with the per-channel sums, clamping and byte selection. A stall on the output
// side freezes the whole path, while the input register still holds one waiting word. The
// coefficient store is six memories with one write and one read port, one per tap, each
// MAX_PHASES deep; coefficients never written read as whatever the memory holds. The user must
// write configuration only while the block is idle; the block itself does not enforce it.
module polyphase_line_resampler_core #(
  parameter int unsigned MAX_PHASES = plr_pkg::MAX_PHASES_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  // configuration
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_wdata_i,
  // input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         kind_i,
  input  logic [31:0]        pixel_in_i,
  input  logic [4:0]         coef_phase_i,
  input  logic [2:0]         coef_tap_i,
  input  logic signed [15:0] coef_value_i,
  // output channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [31:0]        pixel_out_o,
  output logic               last_o,
  output logic               line_done_o
);
  import plr_pkg::*;

  localparam int unsigned PhW = (MAX_PHASES > 1) ? $clog2(MAX_PHASES) : 1;

  // Configuration registers.
  logic [5:0]  phase_count_q;
  logic [31:0] advance_q;
  logic [8:0]  line_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_count_q <= PCOUNT_RESET;
      advance_q     <= PATTERN_RESET;
      line_limit_q  <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_PHASE_COUNT: phase_count_q <= cfg_wdata_i[5:0];
        CFG_ADVANCE:     advance_q     <= cfg_wdata_i;
        CFG_LINE_LIMIT:  line_limit_q  <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  // The whole result path moves only when the output register can take a word.
  logic adv;
  assign adv = !out_valid_o || !out_stall_i;

  // Input register.
  logic               in_valid_q;
  logic [1:0]         kind_q;
  pix_t               pix_q;
  logic [4:0]         cphase_q;
  logic [2:0]         ctap_q;
  logic signed [15:0] cval_q;

  // Sequencer state.
  win_t       window_q, window_d;
  logic [4:0] phase_q, phase_d;
  logic [31:0] pattern_q, pattern_d;
  logic [9:0] ocount_q, ocount_d;
  preload_e   pre_q, pre_d;
  logic       busy_q, busy_d;
  logic       flush_q, flush_d;
  logic [5:0] n_q, n_d;

  // An item leaves the input register in a cycle in which the sequencer is free and the path moves.
  logic in_take;
  assign in_take    = adv && !busy_q;
  assign in_stall_o = in_valid_q && !in_take;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= (in_valid_q && !in_take) || (in_valid_i && !in_stall_o);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      kind_q   <= kind_i;
      pix_q    <= pixel_in_i;
      cphase_q <= coef_phase_i;
      ctap_q   <= coef_tap_i;
      cval_q   <= coef_value_i;
    end
  end

  // Sequencer: one output phase per cycle while the result path moves.
  win_t        win_eff;
  logic        run;
  logic        run_flush;
  logic [5:0]  n_cur;
  logic        coef_we;
  logic [5:0]  pc_eff;
  logic [4:0]  ph_cur;
  logic [31:0] ps_cur;
  logic        shift_bit;
  logic [9:0]  oc_next;
  logic [5:0]  ph_inc;
  logic        ph_wrap;
  logic [6:0]  n_next;
  logic        line_end;
  tag_t        iss_tag;

  always_comb begin
    window_d  = window_q;
    phase_d   = phase_q;
    pattern_d = pattern_q;
    ocount_d  = ocount_q;
    pre_d     = pre_q;
    busy_d    = busy_q;
    flush_d   = flush_q;
    n_d       = n_q;
    win_eff   = window_q;
    run       = busy_q;
    run_flush = flush_q;
    n_cur     = n_q;
    coef_we   = 1'b0;
    iss_tag   = '0;

    if (!busy_q && in_valid_q) begin
      unique case (kind_q)
        KIND_PIXEL: begin
          unique case (pre_q)
            PRE_FIRST: begin
              for (int t = 0; t < TAPS; t++) window_d[t] = pix_q;
              pre_d = PRE_SECOND;
            end
            PRE_SECOND: begin
              window_d[TAPS-2] = pix_q;
              window_d[TAPS-1] = pix_q;
              pre_d = PRE_RUN;
            end
            PRE_RUN: begin
              win_eff[TAPS-1] = pix_q;
              window_d        = win_eff;
              run             = 1'b1;
              run_flush       = 1'b0;
              n_cur           = '0;
            end
            PRE_OWED: ;
            default: ;
          endcase
        end
        KIND_FLUSH: begin
          if (pre_q != PRE_FIRST) begin
            run       = 1'b1;
            run_flush = 1'b1;
            n_cur     = '0;
          end
        end
        KIND_COEF: begin
          coef_we = (ctap_q < 3'(TAPS)) && ({1'b0, cphase_q} < 6'(MAX_PHASES));
        end
        default: ;
      endcase
    end

    // Phase count out of range is pulled into 1..MAX_PHASES.
    if (phase_count_q == '0) begin
      pc_eff = 6'd1;
    end else if (phase_count_q > 6'(MAX_PHASES)) begin
      pc_eff = 6'(MAX_PHASES);
    end else begin
      pc_eff = phase_count_q;
    end

    ph_cur    = ({1'b0, phase_q} >= pc_eff) ? '0 : phase_q;
    ps_cur    = (ph_cur == '0) ? advance_q : pattern_q;
    shift_bit = ps_cur[0];
    oc_next   = ocount_q + 10'd1;
    ph_inc    = {1'b0, ph_cur} + 6'd1;
    ph_wrap   = ph_inc >= pc_eff;
    n_next    = {1'b0, n_cur} + 7'd1;
    line_end  = ph_wrap && (oc_next >= {1'b0, line_limit_q});

    if (run) begin
      ocount_d  = oc_next;
      pattern_d = {1'b0, ps_cur[31:1]};
      phase_d   = ph_wrap ? '0 : ph_inc[4:0];
      if (shift_bit) begin
        for (int t = 0; t < TAPS - 1; t++) window_d[t] = win_eff[t+1];
        window_d[TAPS-1] = win_eff[TAPS-1];
      end
      busy_d  = 1'b1;
      flush_d = run_flush;
      n_d     = n_next[5:0];
      priority if (line_end) begin
        iss_tag   = '{last: 1'b1, done: 1'b1};
        phase_d   = '0;
        pattern_d = '0;
        ocount_d  = OCOUNT_RESET;
        pre_d     = PRE_FIRST;
        busy_d    = 1'b0;
      end else if (shift_bit && (oc_next < {1'b0, line_limit_q}) && !run_flush) begin
        iss_tag.last = 1'b1;
        pre_d        = PRE_RUN;
        busy_d       = 1'b0;
      end else if (n_next == 7'(MAX_RESULTS)) begin
        iss_tag.last = 1'b1;
        pre_d        = PRE_OWED;
        busy_d       = 1'b0;
      end else begin
        busy_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q  <= '0;
      phase_q   <= '0;
      pattern_q <= '0;
      ocount_q  <= OCOUNT_RESET;
      pre_q     <= PRE_FIRST;
      busy_q    <= 1'b0;
      flush_q   <= 1'b0;
      n_q       <= '0;
    end else if (adv) begin
      window_q  <= window_d;
      phase_q   <= phase_d;
      pattern_q <= pattern_d;
      ocount_q  <= ocount_d;
      pre_q     <= pre_d;
      busy_q    <= busy_d;
      flush_q   <= flush_d;
      n_q       <= n_d;
    end
  end

  // Coefficient store: one memory per tap, read for the phase being issued.
  logic signed [15:0] coef_rd_q [TAPS];
  logic [PhW-1:0]     rd_addr;
  logic [PhW-1:0]     wr_addr;

  assign rd_addr = ph_cur[PhW-1:0];
  assign wr_addr = cphase_q[PhW-1:0];

  for (genvar g = 0; g < TAPS; g++) begin : g_tap
    logic signed [15:0] mem [MAX_PHASES];
    always_ff @(posedge clk_i) begin
      if (adv && coef_we && (ctap_q == 3'(g))) begin
        mem[wr_addr] <= cval_q;
      end
      if (adv) begin
        coef_rd_q[g] <= mem[rd_addr];
      end
    end
  end

  // Result pipeline: window snapshot, products, sums and clamp.
  logic               s1_valid_q, s2_valid_q, out_valid_q;
  win_t               s1_win_q;
  tag_t               s1_tag_q, s2_tag_q, out_tag_q;
  logic signed [24:0] s2_prod_q [CH][TAPS];
  logic signed [24:0] prod_d    [CH][TAPS];
  logic signed [27:0] sum_d     [CH];
  pix_t               pix_d;
  pix_t               pix_out_q;

  always_comb begin
    for (int c = 0; c < CH; c++) begin
      for (int t = 0; t < TAPS; t++) begin
        prod_d[c][t] = $signed({1'b0, s1_win_q[t][c*8 +: 8]}) * coef_rd_q[t];
      end
    end
  end

  always_comb begin
    pix_d = '0;
    for (int c = 0; c < CH; c++) begin
      sum_d[c] = '0;
      for (int t = 0; t < TAPS; t++) begin
        sum_d[c] = sum_d[c] + 28'(s2_prod_q[c][t]);
      end
      if (sum_d[c] < 28'sd0) begin
        pix_d[c*8 +: 8] = 8'h00;
      end else if (sum_d[c] > SUM_MAX) begin
        pix_d[c*8 +: 8] = SUM_MAX[21:14];
      end else begin
        pix_d[c*8 +: 8] = sum_d[c][21:14];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s2_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      s1_valid_q  <= run;
      s2_valid_q  <= s1_valid_q;
      out_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_win_q  <= win_eff;
      s1_tag_q  <= iss_tag;
      s2_prod_q <= prod_d;
      s2_tag_q  <= s1_tag_q;
      pix_out_q <= pix_d;
      out_tag_q <= s2_tag_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pix_out_q;
  assign last_o      = out_tag_q.last;
  assign line_done_o = out_tag_q.done;

endmodule

FILE: hdl/plr_checker.sv
// Port-level assertions for the line resampler, bound to its top level.
module plr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [31:0] pixel_out_o,
  input logic        last_o,
  input logic        line_done_o
);
  import plr_pkg::*;

  logic       seen_q;
  logic [6:0] run_cnt_q;
  logic       out_take;

  assign out_take = out_valid_o && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= 1'b0;
      run_cnt_q <= '0;
    end else begin
      if (in_valid_i && !in_stall_o) seen_q <= 1'b1;
      if (out_take) begin
        run_cnt_q <= last_o ? '0 : run_cnt_q + 7'd1;
      end
    end
  end

  // A stalled result word stays put.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_out_o) && $stable(last_o))
    else $error("result word changed under stall");

  // The word that ends a line also ends the item's results.
  a_done_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && line_done_o |-> last_o)
    else $error("line end without last");

  // No item gives more than the result cap.
  a_result_cap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_take && !last_o |-> run_cnt_q < 7'(MAX_RESULTS - 1))
    else $error("too many results for one word");

  // Results only follow accepted input words.
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> seen_q)
    else $error("result before any input word");

endmodule

bind polyphase_line_resampler_core plr_checker u_plr_checker (.*);

FILE: bench/testbench.sv
// Self-checking testbench of the polyphase line resampler core, with its own line predictor.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import plr_pkg::*;

  // Kind code that the block has no use for; it must be dropped without a result.
  localparam logic [1:0] KIND_RESERVED = 2'd3;
  // Cycles allowed for a word that gives no result to leave the pipeline.
  localparam int DRAIN_CYCLES = 12;
  localparam int RANDOM_WORDS = 320;

  typedef struct packed {
    pix_t pix;
    logic last;
    logic done;
  } resamp_word_t;

  typedef struct packed {
    logic [1:0]         kind;
    pix_t               pix;
    logic [4:0]         phase;
    logic [2:0]         tap;
    logic signed [15:0] coef;
    int                 n_typed;  // -1: take the predicted words, else number typed in
    resamp_word_t       want;
  } stim_row_t;

  localparam resamp_word_t NO_WORD = '0;

  // Directed words. The pixels walk the edge-filled window through a unity tap 0, so the
  // first outputs can be read off directly; the rest of the rows rely on the predictor.
  localparam int SCRIPT_LEN = 24;
  localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
    '{KIND_FLUSH,    32'h0000_0000, 5'd0,  3'd0, 16'sd0,      0, NO_WORD},
    '{KIND_RESERVED, 32'hFFFF_FFFF, 5'd31, 3'd7, -16'sd1,     0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd0, 16'sd16384,  0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd1, 16'sd0,      0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd2, 16'sd0,      0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd3, 16'sd0,      0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd4, 16'sd0,      0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd5, 16'sd0,      0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd6, -16'sd32768, 0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd31, 3'd7, 16'sd32767,  0, NO_WORD},
    '{KIND_PIXEL,    32'hFFFF_FFFF, 5'd0,  3'd0, 16'sd0,      0, NO_WORD},
    '{KIND_PIXEL,    32'h0000_0000, 5'd0,  3'd0, 16'sd0,      0, NO_WORD},
    '{KIND_PIXEL,    32'h8040_2010, 5'd0,  3'd0, 16'sd0,      1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{KIND_PIXEL,    32'h0000_FF00, 5'd0,  3'd0, 16'sd0,      1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{KIND_PIXEL,    32'h00FF_00FF, 5'd0,  3'd0, 16'sd0,      1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{KIND_PIXEL,    32'h7F7F_7F7F, 5'd0,  3'd0, 16'sd0,      1, '{32'hFFFF_FFFF, 1'b1, 1'b0}},
    '{KIND_PIXEL,    32'h0102_0304, 5'd0,  3'd0, 16'sd0,      1, '{32'h0000_0000, 1'b1, 1'b0}},
    '{KIND_PIXEL,    32'hDEAD_BEEF, 5'd0,  3'd0, 16'sd0,      1, '{32'h8040_2010, 1'b1, 1'b0}},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd0, -16'sd32768, 0, NO_WORD},
    '{KIND_COEF,     32'h0000_0000, 5'd0,  3'd1, 16'sd32767,  0, NO_WORD},
    '{KIND_PIXEL,    32'hA5A5_A5A5, 5'd0,  3'd0, 16'sd0,     -1, NO_WORD},
    '{KIND_FLUSH,    32'h0000_0000, 5'd0,  3'd0, 16'sd0,     -1, NO_WORD},
    '{KIND_PIXEL,    32'h5A5A_5A5A, 5'd0,  3'd0, 16'sd0,      0, NO_WORD},
    '{KIND_FLUSH,    32'h0000_0000, 5'd0,  3'd0, 16'sd0,     -1, NO_WORD}
  };

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               cfg_we = 1'b0;
  logic [1:0]         cfg_idx = CFG_PHASE_COUNT;
  logic [31:0]        cfg_wdata = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = KIND_PIXEL;
  pix_t               in_pixel = '0;
  logic [4:0]         in_phase = '0;
  logic [2:0]         in_tap = '0;
  logic signed [15:0] in_coef = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  pix_t               out_pixel;
  logic               out_last;
  logic               out_done;

  polyphase_line_resampler_core dut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .kind_i       (in_kind),
    .pixel_in_i   (in_pixel),
    .coef_phase_i (in_phase),
    .coef_tap_i   (in_tap),
    .coef_value_i (in_coef),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .pixel_out_o  (out_pixel),
    .last_o       (out_last),
    .line_done_o  (out_done)
  );

  // Predicted line state and register settings.
  pix_t        win [TAPS];
  int          coef_mem [MAX_PHASES_DEF][TAPS];
  bit          coef_set [MAX_PHASES_DEF][TAPS];
  int unsigned phase_at;
  logic [31:0] shift_bits;
  logic [9:0]  out_count;
  preload_e    fill_state;
  logic [5:0]  set_phases;
  logic [31:0] set_pattern;
  logic [8:0]  set_limit;

  resamp_word_t fresh_q [$];     // words predicted for the word just accepted
  resamp_word_t filtered_q [$];  // filtered pixels still owed by the block

  int errors = 0;
  int words_in = 0;
  int stream_words = 0;
  int pixels_checked = 0;
  int lines_done = 0;
  int settings_written = 0;
  int src_pct = 0;
  int sink_pct = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  initial begin
    #20_000_000;
    $display("polyphase_line_resampler_core regression: fail");
    $finish;
  end

  function automatic int unsigned active_phases();
    if (set_phases == 0) return 1;
    if (set_phases > MAX_PHASES_DEF) return MAX_PHASES_DEF;
    return set_phases;
  endfunction

  function automatic void line_restart();
    phase_at = 0;
    shift_bits = '0;
    out_count = OCOUNT_RESET;
    fill_state = PRE_FIRST;
  endfunction

  // One output pixel: per channel, six bytes times the phase's Q14 taps, clamped, bits 21..14.
  function automatic pix_t filter_phase(int unsigned ph);
    pix_t res;
    int   sum;
    res = '0;
    for (int ch = 0; ch < CH; ch++) begin
      sum = 0;
      for (int t = 0; t < TAPS; t++) begin
        sum += int'(win[t][ch*8 +: 8]) * coef_mem[ph][t];
      end
      if (sum > SUM_MAX) sum = SUM_MAX;
      if (sum < 0) sum = 0;
      res[ch*8 +: 8] = sum[21:14];
    end
    return res;
  endfunction

  // Produces output phases until the window wants a pixel, the line ends or the cap is hit.
  function automatic void run_phases(bit flushing);
    int unsigned  pc;
    int           n;
    bit           adv;
    bit           busy;
    resamp_word_t w;
    pc = active_phases();
    n = 0;
    busy = 1'b1;
    while (busy) begin
      if (phase_at >= pc) phase_at = 0;
      if (phase_at == 0) shift_bits = set_pattern;
      w.pix = filter_phase(phase_at);
      w.last = 1'b0;
      w.done = 1'b0;
      out_count = out_count + 10'd1;
      adv = shift_bits[0];
      shift_bits = shift_bits >> 1;
      if (adv) begin
        for (int t = 0; t < TAPS - 1; t++) win[t] = win[t + 1];
      end
      phase_at++;
      if (phase_at >= pc) phase_at = 0;
      n++;
      if (phase_at == 0 && out_count >= set_limit) begin
        w.last = 1'b1;
        w.done = 1'b1;
        busy = 1'b0;
        line_restart();
      end else if (adv && out_count < set_limit && !flushing) begin
        w.last = 1'b1;
        busy = 1'b0;
        fill_state = PRE_RUN;
      end else if (n == MAX_RESULTS) begin
        w.last = 1'b1;
        busy = 1'b0;
        fill_state = PRE_OWED;
      end
      fresh_q.push_back(w);
    end
  endfunction

  function automatic void resample_word(logic [1:0] k, pix_t px, logic [4:0] ph,
                                        logic [2:0] tp, logic signed [15:0] cv);
    case (k)
      KIND_COEF: begin
        if (tp < TAPS) begin
          coef_mem[ph][tp] = cv;
          coef_set[ph][tp] = 1'b1;
        end
      end
      KIND_PIXEL: begin
        case (fill_state)
          PRE_FIRST: begin
            for (int t = 0; t < TAPS; t++) win[t] = px;
            fill_state = PRE_SECOND;
          end
          PRE_SECOND: begin
            win[TAPS-2] = px;
            win[TAPS-1] = px;
            fill_state = PRE_RUN;
          end
          PRE_RUN: begin
            win[TAPS-1] = px;
            run_phases(1'b0);
          end
          default: ;  // outputs still owed: the pixel is dropped
        endcase
      end
      KIND_FLUSH: begin
        if (fill_state != PRE_FIRST) run_phases(1'b1);
      end
      default: ;
    endcase
  endfunction

  function automatic logic signed [15:0] pick_coef();
    logic [31:0] r;
    int          v;
    r = $urandom;
    if ($urandom_range(0, 7) == 0) return r[15:0];
    v = int'($urandom_range(0, 20480)) - 4096;
    return v[15:0];
  endfunction

  // Offers one word at the falling edge and waits for the block to take it. Entered and
  // left just after a falling edge.
  task automatic send_word(input logic [1:0] k, input pix_t px, input logic [4:0] ph,
                           input logic [2:0] tp, input logic signed [15:0] cv,
                           input int n_typed, input resamp_word_t typed);
    int gap;
    bit dropped;
    if (src_pct != 0 && $urandom_range(0, 99) < src_pct) begin
      gap = $urandom_range(1, 16);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= k;
    in_pixel <= px;
    in_phase <= ph;
    in_tap   <= tp;
    in_coef  <= cv;
    do @(posedge clk); while (in_stall);
    words_in++;
    dropped = (k == KIND_RESERVED) || (k == KIND_PIXEL && fill_state == PRE_OWED) ||
              (k == KIND_FLUSH && fill_state == PRE_FIRST);
    if (!dropped && k != KIND_COEF) stream_words++;
    fresh_q.delete();
    resample_word(k, px, ph, tp, cv);
    if (n_typed < 0) begin
      foreach (fresh_q[i]) filtered_q.push_back(fresh_q[i]);
    end else if (n_typed == 1) begin
      filtered_q.push_back(typed);
    end
    @(negedge clk);
  endtask

  // Holds the input back until every owed pixel has come out and the pipeline is empty.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (filtered_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_settings(input logic [31:0] pc_word, input logic [31:0] pat_word,
                                input logic [31:0] lim_word);
    cfg_we    <= 1'b1;
    cfg_idx   <= CFG_PHASE_COUNT;
    cfg_wdata <= pc_word;
    @(negedge clk);
    cfg_idx   <= CFG_ADVANCE;
    cfg_wdata <= pat_word;
    @(negedge clk);
    cfg_idx   <= CFG_LINE_LIMIT;
    cfg_wdata <= lim_word;
    @(negedge clk);
    cfg_we    <= 1'b0;
    set_phases  = pc_word[5:0];
    set_pattern = pat_word;
    set_limit   = lim_word[8:0];
    settings_written++;
  endtask

  // Every tap of every phase in use must hold a written value before a pixel is filtered.
  task automatic load_missing_coefs();
    for (int p = 0; p < active_phases(); p++) begin
      for (int t = 0; t < TAPS; t++) begin
        if (!coef_set[p][t]) begin
          send_word(KIND_COEF, $urandom, p[4:0], t[2:0], pick_coef(), -1, NO_WORD);
        end
      end
    end
  endtask

  task automatic close_line();
    while (fill_state != PRE_FIRST) begin
      send_word(KIND_FLUSH, $urandom, $urandom_range(0, 31), $urandom_range(0, 7),
                pick_coef(), -1, NO_WORD);
    end
  endtask

  // Output side: random stall bursts driven at the falling edge.
  initial begin : sink_stall
    int burst;
    burst = 0;
    forever begin
      @(negedge clk);
      if (burst > 0) begin
        burst--;
        out_stall <= 1'b1;
      end else if (sink_pct != 0 && $urandom_range(0, 99) < sink_pct) begin
        burst = $urandom_range(1, 16) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Every word the block hands over is compared with the oldest owed pixel.
  initial begin : result_check
    resamp_word_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        if (filtered_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected word: pixel_out %08h last %b line_done %b",
                   $time, out_pixel, out_last, out_done);
        end else begin
          want = filtered_q.pop_front();
          pixels_checked++;
          if (want.done) lines_done++;
          if (out_pixel !== want.pix) begin
            errors++;
            $display("%0t: pixel_out mismatch: expected %08h, actual %08h",
                     $time, want.pix, out_pixel);
          end
          if (out_last !== want.last) begin
            errors++;
            $display("%0t: last mismatch: expected %b, actual %b", $time, want.last, out_last);
          end
          if (out_done !== want.done) begin
            errors++;
            $display("%0t: line_done mismatch: expected %b, actual %b",
                     $time, want.done, out_done);
          end
        end
      end
    end
  end

  initial begin : stimulus
    int          setting_no;
    int          random_start;
    int          lines;
    int          n_words;
    int          pick;
    int unsigned pc;
    logic [31:0] pat;
    int unsigned lim;

    set_phases  = PCOUNT_RESET;
    set_pattern = PATTERN_RESET;
    set_limit   = LIMIT_RESET;
    foreach (win[t]) win[t] = '0;
    line_restart();

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, run under the reset settings.
    src_pct  = 15;
    sink_pct = 15;
    for (int i = 0; i < SCRIPT_LEN; i++) begin
      send_word(SCRIPT[i].kind, SCRIPT[i].pix, SCRIPT[i].phase, SCRIPT[i].tap,
                SCRIPT[i].coef, SCRIPT[i].n_typed, SCRIPT[i].want);
    end
    close_line();

    // Random part: one register setting per pass, a few lines of random content each.
    random_start = stream_words;
    setting_no = 0;
    while (stream_words - random_start < RANDOM_WORDS) begin
      wait_idle();
      case (setting_no)
        0: begin pc = 32; pat = $urandom; lim = $urandom_range(40, 160); end
        1: begin pc = 0;  pat = 32'h0000_0000; lim = 511; end
        2: begin pc = 63; pat = 32'hFFFF_FFFF; lim = 0; end
        3: begin pc = 1;  pat = 32'h0000_0001; lim = 1; end
        4: begin pc = $urandom_range(1, 4); pat = $urandom; lim = 2; end
        5: begin pc = 1;  pat = 32'h0000_0001; lim = 3; end
        default: begin
          pc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 63) : $urandom_range(1, 8);
          pick = $urandom_range(0, 2);
          pat = (pick == 0) ? $urandom : (pick == 1) ? ($urandom & $urandom)
                                                     : ($urandom | $urandom);
          pick = $urandom_range(0, 7);
          lim = (pick == 0) ? 511 : (pick == 1) ? 3 : $urandom_range(3, 48);
        end
      endcase
      // Unused upper bits of the write data carry noise; only the low bits count.
      write_settings(($urandom & ~32'h3F) | pc, pat, ($urandom & ~32'h1FF) | lim);

      if (stream_words - random_start >= (RANDOM_WORDS * 4) / 5) begin
        src_pct  = 0;
        sink_pct = 0;
      end else begin
        pick = $urandom_range(0, 2);
        src_pct  = (pick == 0) ? 0 : (pick == 1) ? 10 : 25;
        pick = $urandom_range(0, 2);
        sink_pct = (pick == 0) ? 0 : (pick == 1) ? 10 : 25;
      end

      load_missing_coefs();
      lines = $urandom_range(2, 4);
      for (int l = 0; l < lines; l++) begin
        n_words = $urandom_range(3, 20);
        for (int i = 0; i < n_words; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 78) begin
            send_word(KIND_PIXEL, $urandom, $urandom_range(0, 31), $urandom_range(0, 7),
                      pick_coef(), -1, NO_WORD);
          end else if (pick < 88) begin
            send_word(KIND_FLUSH, $urandom, $urandom_range(0, 31), $urandom_range(0, 7),
                      pick_coef(), -1, NO_WORD);
          end else if (pick < 95) begin
            send_word(KIND_COEF, $urandom, $urandom_range(0, 31), $urandom_range(0, 7),
                      pick_coef(), -1, NO_WORD);
          end else begin
            send_word(KIND_RESERVED, $urandom, $urandom_range(0, 31), $urandom_range(0, 7),
                      pick_coef(), -1, NO_WORD);
          end
          // Now and then the sender holds off until the block has caught up.
          if ($urandom_range(0, 49) == 0) wait_idle();
        end
        close_line();
      end
      setting_no++;
    end

    wait_idle();
    $display("Covered %0d input words (%0d pixel or flush words) over %0d register settings.",
             words_in, stream_words, settings_written);
    $display("Checked %0d filtered pixels, %0d of them closing a line.",
             pixels_checked, lines_done);
    if (errors == 0) begin
      $display("polyphase_line_resampler_core regression: pass");
    end else begin
      $display("polyphase_line_resampler_core regression: fail");
    end
    $finish;
  end

endmodule
